>>> rtl/core/cmwc_pkg.sv
// Shared types and constants for the CMWC random generator.
package cmwc_pkg;

  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int WORD_W = 32;
  localparam int CARRY_W = 19;
  localparam int MULT_W = 15;
  localparam int PROD_W = WORD_W + MULT_W;
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd801239084;
  localparam logic [WORD_W-1:0] GOLDEN_STEP = 32'h9e3779b9;
  localparam logic [WORD_W-1:0] GOLDEN_STEP2 = 32'h3c6ef372;
  localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
  localparam logic [MULT_W-1:0] MULTIPLIER = 15'd18782;
  localparam logic [WORD_W-1:0] COMPLEMENT_BASE = 32'hfffffffe;
  localparam logic [WORD_W-1:0] FULL_WORD = 32'hffffffff;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCALE,
    ST_READ,
    ST_MUL,
    ST_UPD,
    ST_QUOT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/cmwc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module cmwc_div import cmwc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [WORD_W-1:0]    dvs_r, dvs_nxt;

  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_r, quo_r[WORD_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> rtl/core/cmwc_random_generator.sv
// Top level: CMWC generator with lag table memory, sequencer and shared divider.
// Bound zero: read, multiply and table update; out_valid comes as busy drops.
// Nonzero bound: a divide forms the scale, then each draw updates the table and divides
// until a draw is kept; out_valid comes as busy drops, when a new start can be taken.
// Reset and every seed write refill the table, one word per cycle, busy until it is full.
// Results are one-cycle strobes; the receiver cannot stall.
module cmwc_random_generator import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_bound,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_value,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_t               state_r, state_nxt;
  logic [WORD_W-1:0]    seed_r, seed_nxt;
  logic [AW-1:0]        fill_cnt_r, fill_cnt_nxt;
  logic [WORD_W-1:0]    h1_r, h1_nxt, h2_r, h2_nxt, h3_r, h3_nxt;
  logic [CARRY_W-1:0]   carry_r, carry_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [WORD_W-1:0]    bound_r, bound_nxt;
  logic [WORD_W-1:0]    scale_r, scale_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_value_r, out_value_nxt;
  logic [WORD_W-1:0]    rd_data_r;

  logic [WORD_W-1:0]    mem [TABLE_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic [AW-1:0]        pos_adv;
  logic [WORD_W-1:0]    fill_word;
  logic [PROD_W:0]      t_sum;
  logic [PROD_W-WORD_W:0] c_hi;
  logic [WORD_W-1:0]    x_raw, x_fix, draw_word;
  logic                 wrap;
  logic [CARRY_W-1:0]   carry_upd;
  logic                 accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cmwc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign pos_adv = (pos_r == LAST_ADDR) ? '0 : pos_r + AW'(1);

  // seeding recurrence
  always_comb begin
    case (fill_cnt_r)
      AW'(0):  fill_word = seed_r;
      AW'(1):  fill_word = seed_r + GOLDEN_STEP;
      AW'(2):  fill_word = seed_r + GOLDEN_STEP2;
      default: fill_word = h3_r ^ h2_r ^ GOLDEN_STEP ^ WORD_W'(fill_cnt_r);
    endcase
  end

  // multiply-with-carry step
  always_comb begin
    t_sum     = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(carry_r);
    c_hi      = t_sum[PROD_W:WORD_W];
    x_raw     = t_sum[WORD_W-1:0] + WORD_W'(c_hi);
    wrap      = x_raw < WORD_W'(c_hi);
    x_fix     = wrap ? x_raw + WORD_W'(1) : x_raw;
    carry_upd = CARRY_W'(c_hi) + CARRY_W'(wrap);
    draw_word = COMPLEMENT_BASE - x_fix;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL:  if (fill_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = (in_bound == '0) ? ST_READ : ST_SCALE;
      ST_SCALE: if (div_rsp.done) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = (bound_r == '0) ? ST_IDLE : ST_QUOT;
      ST_QUOT: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.quotient < bound_r) ? ST_IDLE : ST_READ;
        end
      end
      default:  state_nxt = ST_FILL;
    endcase
    if (cfg_we) state_nxt = ST_FILL;
  end

  // outputs and datapath
  always_comb begin
    seed_nxt      = seed_r;
    fill_cnt_nxt  = fill_cnt_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    h3_nxt        = h3_r;
    carry_nxt     = carry_r;
    pos_nxt       = pos_r;
    bound_nxt     = bound_r;
    scale_nxt     = scale_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = draw_word;
    div_req       = '0;
    case (state_r)
      ST_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = fill_cnt_r;
        mem_wdata    = fill_word;
        h3_nxt       = h2_r;
        h2_nxt       = h1_r;
        h1_nxt       = fill_word;
        fill_cnt_nxt = fill_cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          bound_nxt        = in_bound;
          div_req.start    = in_bound != '0;
          div_req.dividend = FULL_WORD;
          div_req.divisor  = in_bound;
        end
      end
      ST_SCALE: if (div_rsp.done) scale_nxt = div_rsp.quotient;
      ST_READ:  pos_nxt = pos_adv;
      ST_MUL:   prod_nxt = PROD_W'(MULTIPLIER) * PROD_W'(rd_data_r);
      ST_UPD: begin
        mem_we    = 1'b1;
        carry_nxt = carry_upd;
        if (bound_r == '0) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = draw_word;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = draw_word;
          div_req.divisor  = scale_r;
        end
      end
      ST_QUOT: begin
        if (div_rsp.done && (div_rsp.quotient < bound_r)) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = div_rsp.quotient;
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      seed_nxt     = cfg_wdata;
      fill_cnt_nxt = '0;
      carry_nxt    = CARRY_RESET;
      pos_nxt      = LAST_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      seed_r      <= SEED_RESET;
      fill_cnt_r  <= '0;
      carry_r     <= CARRY_RESET;
      pos_r       <= LAST_ADDR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      carry_r     <= carry_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    h1_r        <= h1_nxt;
    h2_r        <= h2_nxt;
    h3_r        <= h3_nxt;
    bound_r     <= bound_nxt;
    scale_r     <= scale_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
  end

  // lag table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[pos_adv];
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_out_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result beat while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> busy)
    else $error("busy not raised after accepted beat");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_SCALE || state_r == ST_QUOT))
    else $error("divider finished outside a divide state");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_ADDR)
    else $error("table position out of range");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD && bound_r != '0 |-> scale_r != '0)
    else $error("zero scale used as divisor");

endmodule

>>> sim/cmwc_checker.sv
// Checker for the CMWC generator: mirrors the lag table, predicts each draw and compares results.
module cmwc_checker import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [WORD_W-1:0] in_bound,
  input  logic              out_valid,
  input  logic [WORD_W-1:0] out_value,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  output int                pending,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WORD_W-1:0] lag_table [TABLE_DEPTH];
  logic [WORD_W-1:0] carry;
  int                position;
  logic [WORD_W-1:0] pending_values [$];
  int                mismatch_count = 0;

  function void refill_table(input logic [WORD_W-1:0] seed_word);
    carry = WORD_W'(CARRY_RESET);
    position = TABLE_DEPTH - 1;
    lag_table[0] = seed_word;
    lag_table[1] = seed_word + GOLDEN_STEP;
    lag_table[2] = seed_word + GOLDEN_STEP2;
    for (int n = 3; n < TABLE_DEPTH; n++) begin
      lag_table[n] = lag_table[n-3] ^ lag_table[n-2] ^ GOLDEN_STEP ^ WORD_W'(n);
    end
  endfunction

  function logic [WORD_W-1:0] next_word();
    logic [63:0]       t;
    logic [WORD_W-1:0] x;
    position = (position == TABLE_DEPTH - 1) ? 0 : position + 1;
    t = 64'(MULTIPLIER) * 64'(lag_table[position]) + 64'(carry);
    carry = t[63:32];
    x = t[31:0] + carry;
    if (x < carry) begin
      x = x + 1;
      carry = carry + 1;
    end
    lag_table[position] = COMPLEMENT_BASE - x;
    return lag_table[position];
  endfunction

  // scaled division with rejection; bound zero gives the raw word
  function logic [WORD_W-1:0] draw_below_bound(input logic [WORD_W-1:0] bound);
    logic [WORD_W-1:0] scale;
    logic [WORD_W-1:0] quot;
    if (bound == '0) begin
      return next_word();
    end
    scale = FULL_WORD / bound;
    do begin
      quot = next_word() / scale;
    end while (quot >= bound);
    return quot;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      refill_table(SEED_RESET);
      pending_values.delete();
    end else begin
      if (cfg_we) begin
        refill_table(cfg_wdata);
      end
      // one beat per start edge with busy low
      if (start && !busy) begin
        pending_values.push_back(draw_below_bound(in_bound));
      end
      if (out_valid) begin
        if (pending_values.size() == 0) begin
          $display("%0t: result %h with nothing expected", $realtime, out_value);
          mismatch_count++;
        end else begin
          if (out_value !== pending_values[0]) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $realtime, pending_values[0], out_value);
            mismatch_count++;
          end
          void'(pending_values.pop_front());
        end
      end
    end
    pending <= pending_values.size();
    fail_count <= mismatch_count;
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the CMWC generator: clock, reset, seed phases, bound stimulus and verdict.
module tb_top import cmwc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] in_bound = '0;
  logic              out_valid;
  logic [WORD_W-1:0] out_value;
  logic              cfg_we = 1'b0;
  logic [WORD_W-1:0] cfg_wdata = '0;
  int                pending;
  int                fail_count;
  bit                no_gap = 1'b0;
  int                issued = 0;

  logic [WORD_W-1:0] corner_bounds [14] = '{
    32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 32'h7, 32'hffffffff, 32'hfffffffe,
    32'h80000000, 32'h7fffffff, 32'h80000001, 32'h55555555, 32'haaaaaaaa, 32'd1000
  };

  cmwc_random_generator #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_bound  (in_bound),
    .out_valid (out_valid),
    .out_value (out_value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cmwc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_bound   (in_bound),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("cmwc_random_generator verification failed");
    $finish;
  end

  // drives start with the bound; returns once the generator has accepted it
  task automatic issue_bound(input logic [WORD_W-1:0] bound);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_bound <= bound;
    do @(posedge clk); while (busy);
    issued++;
    if (issued % 50 == 0) begin
      no_gap = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] seed_word);
    cfg_wdata <= seed_word;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] random_bound();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return WORD_W'($urandom_range(1, 16));
      4:       return WORD_W'($urandom_range(1, 65536));
      5:       return 32'h80000000 + WORD_W'($urandom_range(0, 4095));
      6:       return 32'hffffffff - WORD_W'($urandom_range(0, 255));
      7:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input logic [WORD_W-1:0] seed_word, input int count);
    drain();
    write_seed(seed_word);
    for (int i = 0; i < count; i++) begin
      issue_bound(random_bound());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed, corner bounds
    foreach (corner_bounds[i]) issue_bound(corner_bounds[i]);
    drain();
    write_seed('0);
    issue_bound(32'h0);
    issue_bound(32'h1);
    issue_bound(32'hffffffff);
    issue_bound(32'h80000000);
    drain();
    write_seed(32'hffffffff);
    issue_bound(32'h0);
    issue_bound(32'h10000);
    issue_bound(32'hffffffff);
    issue_bound(32'd5);

    random_phase($urandom, 120);
    random_phase('0, 120);
    random_phase(32'hffffffff, 120);
    random_phase(SEED_RESET, 120);
    random_phase($urandom, 950);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("cmwc_random_generator verification clean");
    end else begin
      $display("cmwc_random_generator verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cmwc_pkg.sv
rtl/core/cmwc_div.sv
rtl/core/cmwc_random_generator.sv
sim/cmwc_checker.sv
sim/tb_top.sv
